### rtl/character_lcd_4bit_interface_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD 4-bit interface core
// Concurrent check wrappers that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef CHARACTER_LCD_4BIT_INTERFACE_CORE_ASSERT_SVH
`define CHARACTER_LCD_4BIT_INTERFACE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// If the antecedent holds, the consequent holds at the same edge.
`define LCD4_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("LCD4 same-cycle check failed");

// If the antecedent holds, the consequent holds at the next edge.
`define LCD4_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("LCD4 next-cycle check failed");

`else

`define LCD4_ASSERT_IMP(label, clk, rst, ante, cons)
`define LCD4_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/lcd4_pkg.sv
// ----------------------------------------------------------------------------
// LCD 4-bit interface package
// Types, codes and the power-on command list shared by the LCD core modules.
// ----------------------------------------------------------------------------
package lcd4_pkg;

   // Item kinds on the request channel.
   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_BYTE   = 2'd1;
   localparam logic [1:0] KIND_INIT   = 2'd2;
   localparam logic [1:0] KIND_LOCATE = 2'd3;

   // Sequencer phase codes.
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_HIGH   = 3'd1;
   localparam logic [2:0] PH_LOW    = 3'd2;
   localparam logic [2:0] PH_SETTLE = 3'd3;
   localparam logic [2:0] PH_EXTRA  = 3'd4;
   localparam logic [2:0] PH_FINAL  = 3'd5;

   // Power-on command list.
   localparam logic [2:0] INIT_LEN   = 3'd6;
   localparam logic [2:0] INIT_LAST  = 3'd5;
   localparam logic [2:0] INIT_SLOW  = 3'd2;
   localparam logic [7:0] CMD_CLEAR  = 8'h01;

   // Set-address command and the offset of the second row.
   localparam logic [7:0] CMD_SET_ADDR = 8'h80;
   localparam logic [7:0] ROW2_OFFSET  = 8'h40;
   localparam logic [1:0] ROW_FIRST    = 2'd1;
   localparam logic [1:0] ROW_SECOND   = 2'd2;

   // Control register indexes.
   localparam logic [2:0] CSR_ENABLE_PULSE = 3'd0;
   localparam logic [2:0] CSR_SETTLE       = 3'd1;
   localparam logic [2:0] CSR_INIT_EXTRA   = 3'd2;
   localparam logic [2:0] CSR_INIT_FINAL   = 3'd3;

   // Control register reset values.
   localparam logic [7:0] ENABLE_PULSE_RESET = 8'd2;
   localparam logic [7:0] SETTLE_RESET       = 8'd2;
   localparam logic [7:0] INIT_EXTRA_RESET   = 8'd4;
   localparam logic [9:0] INIT_FINAL_RESET   = 10'd200;

   typedef struct packed {
      logic [7:0] enable_pulse_ticks;
      logic [7:0] settle_ticks;
      logic [7:0] init_extra_ticks;
      logic [9:0] init_final_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       register_select;
      logic [7:0] value;
      logic [1:0] row;
      logic [5:0] column;
   } item_type;

   typedef struct packed {
      logic [3:0] data_nibble;
      logic       rs_pin;
      logic       enable_pin;
      logic       busy_res;
      logic       rejected;
   } result_type;

   typedef struct packed {
      logic [2:0] phase;
      logic [9:0] wait_count;
      logic [7:0] held_byte;
      logic       held_select;
      logic [2:0] init_step;
      logic       in_init;
      logic [3:0] nibble;
      logic       rs;
      logic       en;
   } seq_state_type;

   // Power-on command list: function set (three times), display on,
   // entry mode and clear.
   function automatic logic [7:0] init_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h33;
         3'd1:    b = 8'h32;
         3'd2:    b = 8'h28;
         3'd3:    b = 8'h0C;
         3'd4:    b = 8'h06;
         3'd5:    b = CMD_CLEAR;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

### rtl/lcd4_seq.sv
// ----------------------------------------------------------------------------
// LCD 4-bit nibble sequencer
// Holds the bus phase, wait counter and pin levels; applies one item per cycle
// while item_accept is high, collapsing any run of expired waits within it.
// ----------------------------------------------------------------------------
module lcd4_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  lcd4_pkg::cfg_type      cfg,
   input  logic                   item_accept,
   input  lcd4_pkg::item_type     item,
   output lcd4_pkg::result_type   result
);
   import lcd4_pkg::*;

   seq_state_type state_ff;
   seq_state_type state_in;
   logic          rejected;

   // Enter the final wait after the last command, or go idle if it is zero.
   function automatic seq_state_type enter_final(input seq_state_type s, input cfg_type c);
      seq_state_type r;
      r = s;
      r.phase      = PH_FINAL;
      r.wait_count = c.init_final_ticks;
      if (c.init_final_ticks == 10'd0) begin
         r.phase   = PH_IDLE;
         r.in_init = 1'b0;
      end
      return r;
   endfunction

   // With zero pulse and zero settle times, the rest of the list goes out at
   // once and leaves the low nibble of the clear command on the bus.
   function automatic seq_state_type run_to_end(input seq_state_type s, input cfg_type c);
      seq_state_type r;
      r = s;
      r.held_byte   = CMD_CLEAR;
      r.held_select = 1'b0;
      r.nibble      = CMD_CLEAR[3:0];
      r.rs          = 1'b0;
      r.en          = 1'b0;
      r.init_step   = INIT_LEN;
      return enter_final(r, c);
   endfunction

   // End of an init gap: start the next command of the list or the final wait.
   function automatic seq_state_type extra_exit(input seq_state_type s, input cfg_type c);
      seq_state_type r;
      logic [2:0]    k;
      logic [7:0]    b;
      r = s;
      k = s.init_step + 3'd1;
      b = init_byte(k);
      r.init_step = k;
      if (k < INIT_LEN) begin
         r.held_byte   = b;
         r.held_select = 1'b0;
         r.rs          = 1'b0;
         if (c.enable_pulse_ticks != 8'd0) begin
            r.nibble     = b[7:4];
            r.en         = 1'b1;
            r.phase      = PH_HIGH;
            r.wait_count = {2'b00, c.enable_pulse_ticks};
         end else begin
            // Both nibbles pass at once; the byte ends with enable low.
            r.nibble = b[3:0];
            r.en     = 1'b0;
            if (c.settle_ticks != 8'd0) begin
               r.phase      = PH_SETTLE;
               r.wait_count = {2'b00, c.settle_ticks};
            end else if (!s.in_init) begin
               r.phase      = PH_IDLE;
               r.wait_count = 10'd0;
            end else if (k < INIT_SLOW && c.init_extra_ticks != 8'd0) begin
               r.phase      = PH_EXTRA;
               r.wait_count = {2'b00, c.init_extra_ticks};
            end else begin
               r = run_to_end(r, c);
            end
         end
      end else begin
         r = enter_final(r, c);
      end
      return r;
   endfunction

   // End of the settle wait: go idle, or take the gap that follows in init.
   function automatic seq_state_type settle_exit(input seq_state_type s, input cfg_type c);
      seq_state_type r;
      logic [9:0]    gap;
      r = s;
      if (!s.in_init) begin
         r.phase      = PH_IDLE;
         r.wait_count = 10'd0;
      end else begin
         if (s.init_step < INIT_SLOW) begin
            gap = {2'b00, c.init_extra_ticks};
         end else if (s.init_step == INIT_LAST) begin
            gap = {2'b00, c.settle_ticks};
         end else begin
            gap = 10'd0;
         end
         r.phase      = PH_EXTRA;
         r.wait_count = gap;
         if (gap == 10'd0) begin
            r = extra_exit(r, c);
         end
      end
      return r;
   endfunction

   // End of the low nibble pulse: drop enable and start the settle wait.
   function automatic seq_state_type low_exit(input seq_state_type s, input cfg_type c);
      seq_state_type r;
      r = s;
      r.nibble = s.held_byte[3:0];
      r.rs     = s.held_select;
      r.en     = 1'b0;
      r.phase  = PH_SETTLE;
      r.wait_count = {2'b00, c.settle_ticks};
      if (c.settle_ticks == 8'd0) begin
         r = settle_exit(r, c);
      end
      return r;
   endfunction

   // End of the high nibble pulse: enable stays high into the low nibble.
   function automatic seq_state_type high_exit(input seq_state_type s, input cfg_type c);
      seq_state_type r;
      r = s;
      if (c.enable_pulse_ticks != 8'd0) begin
         r.nibble     = s.held_byte[3:0];
         r.rs         = s.held_select;
         r.en         = 1'b1;
         r.phase      = PH_LOW;
         r.wait_count = {2'b00, c.enable_pulse_ticks};
      end else begin
         r = low_exit(r, c);
      end
      return r;
   endfunction

   // Follow expired waits until a phase with time left, or idle.
   function automatic seq_state_type resolve(input seq_state_type s, input cfg_type c);
      seq_state_type r;
      r = s;
      if (s.phase != PH_IDLE && s.wait_count == 10'd0) begin
         unique case (s.phase)
            PH_HIGH:   r = high_exit(s, c);
            PH_LOW:    r = low_exit(s, c);
            PH_SETTLE: r = settle_exit(s, c);
            PH_EXTRA:  r = extra_exit(s, c);
            default: begin
               r.in_init = 1'b0;
               r.phase   = PH_IDLE;
            end
         endcase
      end
      return r;
   endfunction

   // Latch a byte, show its high nibble with enable raised.
   function automatic seq_state_type begin_byte(input seq_state_type s, input cfg_type c,
                                                input logic [7:0] b, input logic sel);
      seq_state_type r;
      r = s;
      r.held_byte   = b;
      r.held_select = sel;
      r.nibble      = b[7:4];
      r.rs          = sel;
      r.en          = 1'b1;
      r.phase       = PH_HIGH;
      r.wait_count  = {2'b00, c.enable_pulse_ticks};
      return resolve(r, c);
   endfunction

   // Apply the incoming beat to the current state.
   always_comb begin
      logic [7:0] addr;
      seq_state_type s;
      s        = state_ff;
      rejected = 1'b0;
      addr     = {2'b00, item.column} - 8'd1;
      unique case (item.kind)
         KIND_TICK: begin
            if (s.phase != PH_IDLE) begin
               if (s.wait_count != 10'd0) begin
                  s.wait_count = s.wait_count - 10'd1;
               end
               s = resolve(s, cfg);
            end
         end
         KIND_BYTE: begin
            if (s.phase != PH_IDLE) begin
               rejected = 1'b1;
            end else begin
               s = begin_byte(s, cfg, item.value, item.register_select);
            end
         end
         KIND_INIT: begin
            if (s.phase != PH_IDLE) begin
               rejected = 1'b1;
            end else begin
               s.in_init   = 1'b1;
               s.init_step = 3'd0;
               s = begin_byte(s, cfg, init_byte(3'd0), 1'b0);
            end
         end
         default: begin
            // Locate: rows other than rows one and two send nothing.
            if (s.phase != PH_IDLE) begin
               rejected = 1'b1;
            end else if (item.row == ROW_FIRST) begin
               s = begin_byte(s, cfg, addr | CMD_SET_ADDR, 1'b0);
            end else if (item.row == ROW_SECOND) begin
               s = begin_byte(s, cfg, addr | ROW2_OFFSET | CMD_SET_ADDR, 1'b0);
            end
         end
      endcase
      state_in = s;
   end

   // Result reflects the pins and phase after this beat.
   always_comb begin
      result.data_nibble = state_in.nibble;
      result.rs_pin      = state_in.rs;
      result.enable_pin  = state_in.en;
      result.busy_res    = (state_in.phase != PH_IDLE);
      result.rejected    = rejected;
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (item_accept) begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/character_lcd_4bit_interface_core.sv
// ----------------------------------------------------------------------------
// Character LCD 4-bit interface core
// HD44780-style display driver: byte send, power-on list and cursor locate.
// ----------------------------------------------------------------------------
// Usage:
// Request beats (req_*) carry a kind: tick, send byte, start init or locate.
// Time on the display bus moves only on tick beats. Every accepted beat
// produces exactly one response beat (rsp_*) giving the pin levels after it,
// whether a send or init is still running, and whether the beat was dropped
// because the core was busy.
// A beat is taken every cycle while req_stall is low; its response is
// registered in the output buffer. The whole update, including any run of
// zero-length waits, is one logic pass from sequencer state to output register.
// A two-entry output buffer lets a beat enter while a response is held by a
// stalled receiver; req_stall rises only when both entries are full.
// The csr_* port writes the four timing registers; it is always ready and
// should be used only while no beat is in flight.
// Synchronous reset returns to idle with all pins low, empties the output
// buffer and loads the default timings (2, 2, 4 and 200 ticks).
// ----------------------------------------------------------------------------
module character_lcd_4bit_interface_core (
   input  logic       clock,
   input  logic       reset,
   // Request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic       req_register_select,
   input  logic [7:0] req_value,
   input  logic [1:0] req_row,
   input  logic [5:0] req_column,
   // Response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_data_nibble,
   output logic       rsp_rs_pin,
   output logic       rsp_enable_pin,
   output logic       rsp_busy_res,
   output logic       rsp_rejected,
   // Control register write port
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [9:0] csr_wdata
);
   import lcd4_pkg::*;

   `include "character_lcd_4bit_interface_core_assert.svh"

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   item_type   item;
   result_type seq_result;
   result_type out_ff;
   result_type out_in;
   result_type skid_ff;
   result_type skid_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   logic       req_accept;
   logic       rsp_pop;

   // Control registers: out-of-range indexes are ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ENABLE_PULSE: cfg_in.enable_pulse_ticks = csr_wdata[7:0];
            CSR_SETTLE:       cfg_in.settle_ticks       = csr_wdata[7:0];
            CSR_INIT_EXTRA:   cfg_in.init_extra_ticks   = csr_wdata[7:0];
            CSR_INIT_FINAL:   cfg_in.init_final_ticks   = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_pulse_ticks <= ENABLE_PULSE_RESET;
         cfg_ff.settle_ticks       <= SETTLE_RESET;
         cfg_ff.init_extra_ticks   <= INIT_EXTRA_RESET;
         cfg_ff.init_final_ticks   <= INIT_FINAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request beat into the sequencer.
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      item.kind            = req_kind;
      item.register_select = req_register_select;
      item.value           = req_value;
      item.row             = req_row;
      item.column          = req_column;
   end

   lcd4_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .item_accept (req_accept),
      .item        (item),
      .result      (seq_result)
   );

   // Two-entry output buffer: the skid entry catches a beat that arrives
   // while the output entry is held by a stall.
   assign rsp_pop = out_valid_ff && !rsp_stall;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (req_accept) begin
         if (!out_valid_ff || rsp_pop) begin
            out_in       = seq_result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = seq_result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_data_nibble = out_ff.data_nibble;
   assign rsp_rs_pin      = out_ff.rs_pin;
   assign rsp_enable_pin  = out_ff.enable_pin;
   assign rsp_busy_res    = out_ff.busy_res;
   assign rsp_rejected    = out_ff.rejected;

   // The skid entry is only ever filled behind a held output entry.
   `LCD4_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)

   // A beat taken into an empty buffer is offered on the next cycle.
   `LCD4_ASSERT_NXT(a_accept_to_rsp, clock, reset, req_accept && !out_valid_ff, rsp_valid)

   // Ticks are never dropped.
   `LCD4_ASSERT_IMP(a_tick_not_rejected, clock, reset, req_accept && seq_result.rejected,
                    req_kind != KIND_TICK)

   // Once the bus is idle, enable is low.
   `LCD4_ASSERT_IMP(a_idle_enable_low, clock, reset, out_valid_ff && !out_ff.busy_res,
                    !out_ff.enable_pin)

endmodule

### verif/lcd4_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD 4-bit interface pin scoreboard
// Keeps its own copy of the timing registers and the bus sequencer, works out
// the pin levels expected after every accepted request beat and compares them
// with the response beats in order.
// ----------------------------------------------------------------------------
package lcd4_tb_pkg;

   import lcd4_pkg::*;

   class lcd_pin_scoreboard;

      // Copy of the timing registers.
      logic [7:0]  pulse_ticks;
      logic [7:0]  settle_ticks;
      logic [7:0]  extra_ticks;
      logic [9:0]  final_ticks;

      // Copy of the bus sequencer.
      logic [2:0]  phase;
      logic [9:0]  wait_left;
      logic [7:0]  byte_held;
      logic        sel_held;
      logic [2:0]  step;
      logic        initialising;
      logic [3:0]  nibble;
      logic        rs;
      logic        en;

      logic [7:0]  power_on_cmds [6];
      result_type  expected_pins [$];
      int unsigned mismatches;
      int unsigned responses;

      function new();
         power_on_cmds = '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h06, CMD_CLEAR};
         pulse_ticks   = ENABLE_PULSE_RESET;
         settle_ticks  = SETTLE_RESET;
         extra_ticks   = INIT_EXTRA_RESET;
         final_ticks   = INIT_FINAL_RESET;
         phase         = PH_IDLE;
         wait_left     = '0;
         byte_held     = '0;
         sel_held      = 1'b0;
         step          = '0;
         initialising  = 1'b0;
         nibble        = '0;
         rs            = 1'b0;
         en            = 1'b0;
         mismatches    = 0;
         responses     = 0;
      endfunction

      // Register writes are masked to the register width; spare indexes do nothing.
      function void write_reg(logic [2:0] index, logic [9:0] data);
         case (index)
            CSR_ENABLE_PULSE: pulse_ticks  = data[7:0];
            CSR_SETTLE:       settle_ticks = data[7:0];
            CSR_INIT_EXTRA:   extra_ticks  = data[7:0];
            CSR_INIT_FINAL:   final_ticks  = data;
            default: ;
         endcase
      endfunction

      function bit busy();
         return phase != PH_IDLE;
      endfunction

      function int unsigned pending();
         return expected_pins.size();
      endfunction

      // Latch a byte and put its high nibble on the bus with enable raised.
      function void load_byte(logic [7:0] b, logic sel);
         byte_held = b;
         sel_held  = sel;
         nibble    = b[7:4];
         rs        = sel;
         en        = 1'b1;
         phase     = PH_HIGH;
         wait_left = {2'b00, pulse_ticks};
      endfunction

      // Step through every phase whose wait has already run out, so that
      // zero-length waits pass within the same beat.
      function void run_expired();
         while (phase != PH_IDLE && wait_left == '0) begin
            case (phase)
               PH_HIGH: begin
                  // Enable stays high into the low nibble.
                  nibble    = byte_held[3:0];
                  en        = 1'b1;
                  phase     = PH_LOW;
                  wait_left = {2'b00, pulse_ticks};
               end
               PH_LOW: begin
                  en        = 1'b0;
                  phase     = PH_SETTLE;
                  wait_left = {2'b00, settle_ticks};
               end
               PH_SETTLE: begin
                  if (!initialising) begin
                     phase = PH_IDLE;
                  end else if (step < INIT_SLOW) begin
                     phase     = PH_EXTRA;
                     wait_left = {2'b00, extra_ticks};
                  end else if (step == INIT_LAST) begin
                     // The clear command needs a further settle time.
                     phase     = PH_EXTRA;
                     wait_left = {2'b00, settle_ticks};
                  end else begin
                     phase     = PH_EXTRA;
                     wait_left = '0;
                  end
               end
               PH_EXTRA: begin
                  step = step + 3'd1;
                  if (step < INIT_LEN) begin
                     load_byte(power_on_cmds[step], 1'b0);
                  end else begin
                     phase     = PH_FINAL;
                     wait_left = final_ticks;
                  end
               end
               default: begin
                  initialising = 1'b0;
                  phase        = PH_IDLE;
               end
            endcase
         end
      endfunction

      // Apply one accepted request beat and queue the pin levels after it.
      function void predict_pins(item_type it);
         result_type want;
         logic [7:0] addr;
         want.rejected = 1'b0;
         if (it.kind == KIND_TICK) begin
            if (phase != PH_IDLE) begin
               if (wait_left != '0) begin
                  wait_left = wait_left - 10'd1;
               end
               run_expired();
            end
         end else if (phase != PH_IDLE) begin
            want.rejected = 1'b1;
         end else if (it.kind == KIND_BYTE) begin
            load_byte(it.value, it.register_select);
            run_expired();
         end else if (it.kind == KIND_INIT) begin
            initialising = 1'b1;
            step         = '0;
            load_byte(power_on_cmds[0], 1'b0);
            run_expired();
         end else begin
            // Column counts from one; column zero wraps to an all-ones address.
            addr = {2'b00, it.column} - 8'd1;
            if (it.row == ROW_FIRST) begin
               load_byte(addr | CMD_SET_ADDR, 1'b0);
               run_expired();
            end else if (it.row == ROW_SECOND) begin
               load_byte(addr | ROW2_OFFSET | CMD_SET_ADDR, 1'b0);
               run_expired();
            end
         end
         want.data_nibble = nibble;
         want.rs_pin      = rs;
         want.enable_pin  = en;
         want.busy_res    = (phase != PH_IDLE);
         expected_pins.push_back(want);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("mismatch at response %0d: %s", responses, what);
      endtask

      // Compare one response beat with the oldest expectation, field by field.
      task check_pins(result_type got);
         result_type want;
         responses++;
         if (expected_pins.size() == 0) begin
            report_mismatch("response beat with nothing expected");
         end else begin
            want = expected_pins.pop_front();
            if (got.data_nibble !== want.data_nibble)
               report_mismatch($sformatf("data_nibble %h, expected %h",
                                         got.data_nibble, want.data_nibble));
            if (got.rs_pin !== want.rs_pin)
               report_mismatch($sformatf("rs_pin %b, expected %b", got.rs_pin, want.rs_pin));
            if (got.enable_pin !== want.enable_pin)
               report_mismatch($sformatf("enable_pin %b, expected %b",
                                         got.enable_pin, want.enable_pin));
            if (got.busy_res !== want.busy_res)
               report_mismatch($sformatf("busy_res %b, expected %b",
                                         got.busy_res, want.busy_res));
            if (got.rejected !== want.rejected)
               report_mismatch($sformatf("rejected %b, expected %b",
                                         got.rejected, want.rejected));
         end
      endtask

   endclass

endpackage

### verif/character_lcd_4bit_interface_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD 4-bit interface core testbench
// Drives directed and random request beats under several timing settings and
// idle and stall patterns, and checks every response beat against the pin
// scoreboard.
// ----------------------------------------------------------------------------
module character_lcd_4bit_interface_core_tb;

   import lcd4_pkg::*;
   import lcd4_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam logic [2:0]  CSR_SPARE   = 3'd7;

   logic       clock               = 1'b0;
   logic       reset               = 1'b1;
   logic       req_valid           = 1'b0;
   logic       req_stall;
   logic [1:0] req_kind            = KIND_TICK;
   logic       req_register_select = 1'b0;
   logic [7:0] req_value           = '0;
   logic [1:0] req_row             = '0;
   logic [5:0] req_column          = '0;
   logic       rsp_valid;
   logic       rsp_stall           = 1'b0;
   logic [3:0] rsp_data_nibble;
   logic       rsp_rs_pin;
   logic       rsp_enable_pin;
   logic       rsp_busy_res;
   logic       rsp_rejected;
   logic       csr_valid           = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index           = '0;
   logic [9:0] csr_wdata           = '0;

   lcd_pin_scoreboard pins_sb = new();

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   bit          holding_off   = 1'b0;
   int unsigned cycle_count   = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   character_lcd_4bit_interface_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_register_select (req_register_select),
      .req_value           (req_value),
      .req_row             (req_row),
      .req_column          (req_column),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_data_nibble     (rsp_data_nibble),
      .rsp_rs_pin          (rsp_rs_pin),
      .rsp_enable_pin      (rsp_enable_pin),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_rejected        (rsp_rejected),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // Response side: random stalls, or a solid hold-off while one is running.
   always @(negedge clock) begin
      rsp_stall = holding_off || ($urandom_range(99) < rsp_stall_pct);
   end

   // Note every accepted request beat and check every accepted response beat.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            pins_sb.predict_pins(item_type'{req_kind, req_register_select, req_value,
                                            req_row, req_column});
         if (rsp_valid && !rsp_stall)
            pins_sb.check_pins(result_type'{rsp_data_nibble, rsp_rs_pin, rsp_enable_pin,
                                            rsp_busy_res, rsp_rejected});
      end
   end

   // Give up if the run hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // Offer one request beat and hold it until accepted. Entered and left at
   // a falling edge, so back-to-back beats keep valid high.
   task send_item(input item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid           = 1'b1;
      req_kind            = it.kind;
      req_register_select = it.register_select;
      req_value           = it.value;
      req_row             = it.row;
      req_column          = it.column;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task write_reg(input logic [2:0] index, input logic [9:0] data);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      pins_sb.write_reg(index, data);
      @(negedge clock);
   endtask

   // Wait until every expected response beat has arrived.
   task wait_quiet();
      req_valid = 1'b0;
      while (pins_sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task configure(input logic [9:0] pulse, input logic [9:0] settle,
                  input logic [9:0] extra, input logic [9:0] fin);
      wait_quiet();
      write_reg(CSR_ENABLE_PULSE, pulse);
      write_reg(CSR_SETTLE, settle);
      write_reg(CSR_INIT_EXTRA, extra);
      write_reg(CSR_INIT_FINAL, fin);
      csr_valid = 1'b0;
   endtask

   // Hold the response side off for a stretch while the sender carries on.
   task start_hold_off(input int unsigned cycles);
      fork
         begin
            @(posedge clock);
            holding_off = 1'b1;
            repeat (cycles) @(posedge clock);
            holding_off = 1'b0;
         end
      join_none
   endtask

   function automatic item_type noisy_item(input logic [1:0] kind);
      item_type it;
      it.kind            = kind;
      it.register_select = 1'($urandom_range(1));
      it.value           = 8'($urandom_range(255));
      it.row             = 2'($urandom_range(3));
      it.column          = 6'($urandom_range(63));
      return it;
   endfunction

   // Mostly well-formed traffic: ticks while a transfer runs, new work when
   // idle, with a share of beats that arrive while busy.
   function automatic item_type random_item();
      item_type    it;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pins_sb.busy()) begin
         if (pick < 88)
            it = noisy_item(KIND_TICK);
         else
            it = noisy_item(2'($urandom_range(3, 1)));
      end else if (pick < 8) begin
         it = noisy_item(KIND_TICK);
      end else if (pick < 55) begin
         it = noisy_item(KIND_BYTE);
      end else if (pick < 85) begin
         it = noisy_item(KIND_LOCATE);
         if ($urandom_range(9) != 0)
            it.column = 6'($urandom_range(40, 1));
      end else begin
         it = noisy_item(KIND_INIT);
      end
      return it;
   endfunction

   // Tick until the sequencer has finished its current job.
   task drain_sequencer();
      while (pins_sb.busy()) send_item(noisy_item(KIND_TICK));
   endtask

   task run_random(input int unsigned count, input int unsigned hold_at);
      for (int unsigned i = 0; i < count; i++) begin
         if (i == hold_at)
            start_hold_off(60);
         send_item(random_item());
      end
      drain_sequencer();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Default timings: idle tick, a data byte, and work offered while busy.
      send_item(item_type'{KIND_TICK, 1'b1, 8'hFF, 2'd3, 6'd63});
      send_item(item_type'{KIND_BYTE, 1'b1, 8'hA5, 2'd0, 6'd0});
      send_item(item_type'{KIND_BYTE, 1'b0, 8'h00, 2'd0, 6'd0});
      send_item(item_type'{KIND_LOCATE, 1'b0, 8'h00, 2'd0, 6'd1});
      send_item(item_type'{KIND_INIT, 1'b0, 8'h00, 2'd1, 6'd1});
      drain_sequencer();

      // Short timings; a write to a spare index must change nothing.
      configure(10'd1, 10'd0, 10'd1, 10'd2);
      write_reg(CSR_SPARE, 10'h2AA);
      csr_valid = 1'b0;
      send_item(item_type'{KIND_LOCATE, 1'b0, 8'h00, ROW_FIRST, 6'd1});
      drain_sequencer();
      send_item(item_type'{KIND_LOCATE, 1'b1, 8'hFF, ROW_SECOND, 6'd40});
      drain_sequencer();
      // Rows outside the display send nothing and are not rejected.
      send_item(item_type'{KIND_LOCATE, 1'b0, 8'h00, 2'd0, 6'd5});
      send_item(item_type'{KIND_LOCATE, 1'b0, 8'h00, 2'd3, 6'd5});
      // Column zero wraps to an all-ones address.
      send_item(item_type'{KIND_LOCATE, 1'b0, 8'h00, ROW_FIRST, 6'd0});
      drain_sequencer();
      send_item(item_type'{KIND_LOCATE, 1'b0, 8'h00, ROW_SECOND, 6'd63});
      drain_sequencer();
      send_item(item_type'{KIND_INIT, 1'b1, 8'h5A, 2'd2, 6'd7});
      drain_sequencer();

      // Zero waits: a whole byte, and the whole power-on list, in one beat.
      configure(10'd0, 10'd0, 10'd0, 10'd0);
      send_item(item_type'{KIND_BYTE, 1'b1, 8'hFF, 2'd0, 6'd0});
      send_item(item_type'{KIND_INIT, 1'b0, 8'h00, 2'd0, 6'd0});
      send_item(item_type'{KIND_BYTE, 1'b0, 8'h00, 2'd0, 6'd0});
      drain_sequencer();

      // Pulse and settle with upper data bits set; those bits are masked off.
      configure(10'h302, 10'h103, 10'd0, 10'd0);
      send_item(item_type'{KIND_BYTE, 1'b1, 8'h3C, 2'd0, 6'd0});
      drain_sequencer();

      // Masked init gap and a final wait past eight bits, with the shortest pulse.
      configure(10'd1, 10'd0, 10'h105, 10'd260);
      send_item(item_type'{KIND_INIT, 1'b0, 8'h00, 2'd0, 6'd0});
      drain_sequencer();

      // Random traffic under each idle and stall pattern.
      configure(10'($urandom_range(4, 1)), 10'($urandom_range(4)),
                10'($urandom_range(4)), 10'($urandom_range(20)));
      run_random(175, 100);

      configure(10'($urandom_range(4)), 10'($urandom_range(4)),
                10'($urandom_range(4)), 10'($urandom_range(20)));
      send_idle_pct = 77;
      rsp_stall_pct = 0;
      run_random(165, 1000);

      configure(10'($urandom_range(4, 1)), 10'($urandom_range(4)),
                10'($urandom_range(4)), 10'($urandom_range(20)));
      send_idle_pct = 0;
      rsp_stall_pct = 77;
      run_random(165, 150);

      configure(10'($urandom_range(3, 1)), 10'($urandom_range(3)),
                10'($urandom_range(3)), 10'($urandom_range(12)));
      send_idle_pct = 23;
      rsp_stall_pct = 23;
      run_random(165, 1000);

      wait_quiet();
      if (pins_sb.mismatches == 0 && pins_sb.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
